// ----- src/wmf_pkg.sv -----
// Shared types and constants for the 3x3 window median filter.
// No dependencies; imported by every module of the block.
package wmf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int PIXEL_BITS  = 12;
    localparam int ROW_BITS    = 16;
    localparam int WIN_SPAN    = 3;
    localparam int WIN_SIZE    = WIN_SPAN * WIN_SPAN;
    localparam int STORE_ROWS  = 4;
    localparam int BANK_BITS   = $clog2(STORE_ROWS);
    localparam int MED_IDX     = WIN_SIZE / 2;
    localparam int SORT_STAGES = WIN_SIZE;
    localparam int CNT_BITS    = $clog2(WIN_SIZE + 1);
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int WREG_BITS     = 11;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd1;

    localparam logic [WREG_BITS-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [ROW_BITS-1:0]  HEIGHT_RESET = 16'd480;

    typedef logic [PIXEL_BITS-1:0] t_pix;
    typedef logic [COL_BITS-1:0]   t_col;
    typedef t_pix [WIN_SIZE-1:0]   t_win;

    typedef struct packed {
        logic last;
        t_win vals;
    } t_sort_beat;

    typedef struct packed {
        logic [11:0] pixel_value;
        logic        pad;
    } t_in_beat;

    typedef struct packed {
        logic [11:0] median_value;
        logic        frame_last;
    } t_out_beat;

endpackage

// ----- src/wmf_line_bank.sv -----
// One row bank of the line store: one write port, two registered read ports.
// Depends on wmf_pkg for widths.
module wmf_line_bank
    import wmf_pkg::*;
(
    input  logic i_clk,
    input  logic i_we,
    input  t_col i_wr_addr,
    input  t_pix i_wr_data,
    input  logic i_rd_en,
    input  t_col i_rd_addr_a,
    input  t_col i_rd_addr_b,
    output t_pix o_rd_a,
    output t_pix o_rd_b
);

    t_pix mem [MAX_WIDTH];

    // Store one pixel of the row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read two neighboring columns, hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_a <= mem[i_rd_addr_a];
            o_rd_b <= mem[i_rd_addr_b];
        end
    end

endmodule

// ----- src/wmf_sort_cell.sv -----
// One registered round of an odd-even transposition sort over the window.
// Depends on wmf_pkg for the window beat type.
module wmf_sort_cell
    import wmf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_odd,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_sort_beat i_data,
    output logic       o_valid,
    input  logic       i_ready,
    output t_sort_beat o_data
);

    logic       r_valid;
    t_sort_beat r_data;
    t_sort_beat n_data;
    logic       en;

    assign en      = !r_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Compare-exchange the pairs of this round's phase
    always_comb begin
        n_data = i_data;
        for (int j = 0; j < WIN_SIZE - 1; j++) begin
            if (((j % 2) == 1) == i_odd && i_data.vals[j] > i_data.vals[j+1]) begin
                n_data.vals[j]   = i_data.vals[j+1];
                n_data.vals[j+1] = i_data.vals[j];
            end
        end
    end

    // Advance the beat when the next cell can take it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- src/window_median_filter.sv -----
// Top level of the streaming 3x3 median filter: position counters, line
// store banks, window build and the chain of sort cells. Uses wmf_pkg.
// Throughput: one pixel or pad beat per cycle unless the output stalls; a result
// travels through the read stage, the window stage and 9 sort cells in that order.
// Reset (synchronous, active low) restores 640x480 and clears all counters
// and pipeline valids; the line store holds no reset value.
module window_median_filter
    import wmf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  t_in_beat                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output t_out_beat                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    logic [WREG_BITS-1:0] r_width;
    logic [ROW_BITS-1:0]  r_height;
    t_col                 r_in_col, r_out_col;
    logic [ROW_BITS-1:0]  r_in_row, r_out_row;

    logic [WREG_BITS-1:0] w_eff;
    logic [ROW_BITS-1:0]  h_eff;
    t_col                 w_last;
    logic [ROW_BITS-1:0]  h_last;

    logic                 accept, store, emit, last, cfg_acc, cfg_known;
    t_col                 n_in_col;
    logic [ROW_BITS-1:0]  n_in_row;
    logic [ROW_BITS-1:0]  need_r;
    t_col                 need_c;

    logic s1_ready, s2_ready;

    // Stage 1: read data and window position info
    logic                 r_s1_valid;
    logic [BANK_BITS-1:0] r_s1_row;
    t_col                 r_s1_col;
    logic                 r_s1_up, r_s1_dn, r_s1_lf, r_s1_rt, r_s1_last;
    logic                 r_s1_wr;
    logic [BANK_BITS-1:0] r_s1_wbank;
    t_col                 r_s1_wcol;
    t_pix                 r_s1_wdata;

    t_pix rd_a [STORE_ROWS];
    t_pix rd_b [STORE_ROWS];

    // Stage 2: window with fill values
    logic       r_s2_valid;
    t_sort_beat r_s2_data;
    t_pix       r_prev [WIN_SPAN];

    t_pix                 cur [WIN_SPAN];
    t_pix                 nxt [WIN_SPAN];
    logic [BANK_BITS-1:0] bank [WIN_SPAN];
    t_col                 col_nxt;
    logic [WIN_SIZE-1:0]  win_ok;
    logic [CNT_BITS-1:0]  n_ok, n_low, n_bad;
    t_sort_beat           n_s2_data;

    logic       chain_v   [SORT_STAGES+1];
    logic       chain_rdy [SORT_STAGES+1];
    t_sort_beat chain_d   [SORT_STAGES+1];

    // Effective frame size
    always_comb begin
        if (r_width == '0) begin
            w_eff = WREG_BITS'(1);
        end else if (r_width > WREG_BITS'(MAX_WIDTH)) begin
            w_eff = WREG_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        h_eff  = (r_height == '0) ? ROW_BITS'(1) : r_height;
        w_last = COL_BITS'(w_eff - WREG_BITS'(1));
        h_last = h_eff - ROW_BITS'(1);
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;
    assign cfg_known   = (i_cfg_index == REG_WIDTH) || (i_cfg_index == REG_HEIGHT);

    assign o_in_ready = s1_ready;
    assign accept     = i_in_valid && s1_ready;
    assign store      = accept && !i_in_data.pad && (r_in_row < h_eff);

    // Advance the input position
    always_comb begin
        n_in_col = r_in_col;
        n_in_row = r_in_row;
        if (store) begin
            if (r_in_col == w_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_BITS'(1);
            end else begin
                n_in_col = r_in_col + COL_BITS'(1);
            end
        end
    end

    // Decide whether the next output window is complete
    always_comb begin
        need_r = (r_out_row < h_last) ? r_out_row + ROW_BITS'(1) : h_last;
        need_c = (r_out_col < w_last) ? r_out_col + COL_BITS'(1) : w_last;
        emit   = accept && (r_out_row < h_eff) &&
                 ((n_in_row > need_r) || (n_in_row == need_r && n_in_col > need_c));
        last   = (r_out_row == h_last) && (r_out_col == w_last);
    end

    // Configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (cfg_acc && cfg_known) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_width <= i_cfg_data[WREG_BITS-1:0];
            end else begin
                r_height <= i_cfg_data;
            end
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (emit && last) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
            if (emit) begin
                if (r_out_col == w_last) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + ROW_BITS'(1);
                end else begin
                    r_out_col <= r_out_col + COL_BITS'(1);
                end
            end
        end
    end

    // Line store: one bank per row modulo four
    genvar gb;
    generate
        for (gb = 0; gb < STORE_ROWS; gb++) begin : g_bank
            wmf_line_bank u_bank (
                .i_clk       (i_clk),
                .i_we        (store && (r_in_row[BANK_BITS-1:0] == BANK_BITS'(gb))),
                .i_wr_addr   (r_in_col),
                .i_wr_data   (i_in_data.pixel_value),
                .i_rd_en     (s1_ready),
                .i_rd_addr_a (r_out_col),
                .i_rd_addr_b (r_out_col + COL_BITS'(1)),
                .o_rd_a      (rd_a[gb]),
                .o_rd_b      (rd_b[gb])
            );
        end
    endgenerate

    assign s1_ready = !r_s1_valid || s2_ready;

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && emit) begin
            r_s1_row   <= r_out_row[BANK_BITS-1:0];
            r_s1_col   <= r_out_col;
            r_s1_up    <= (r_out_row != '0);
            r_s1_dn    <= (r_out_row < h_last);
            r_s1_lf    <= (r_out_col != '0);
            r_s1_rt    <= (r_out_col < w_last);
            r_s1_last  <= last;
            r_s1_wr    <= store;
            r_s1_wbank <= r_in_row[BANK_BITS-1:0];
            r_s1_wcol  <= r_in_col;
            r_s1_wdata <= i_in_data.pixel_value;
        end
    end

    // Build the window: forward the pixel written with the read
    always_comb begin
        col_nxt = r_s1_col + COL_BITS'(1);
        for (int k = 0; k < WIN_SPAN; k++) begin
            bank[k] = r_s1_row + BANK_BITS'(k + STORE_ROWS - 1);
            cur[k]  = (r_s1_wr && r_s1_wbank == bank[k] && r_s1_wcol == r_s1_col) ?
                      r_s1_wdata : rd_a[bank[k]];
            nxt[k]  = (r_s1_wr && r_s1_wbank == bank[k] && r_s1_wcol == col_nxt) ?
                      r_s1_wdata : rd_b[bank[k]];
        end
        win_ok = {r_s1_dn & r_s1_rt, r_s1_dn, r_s1_dn & r_s1_lf,
                  r_s1_rt, 1'b1, r_s1_lf,
                  r_s1_up & r_s1_rt, r_s1_up, r_s1_up & r_s1_lf};
        n_ok = '0;
        for (int i = 0; i < WIN_SIZE; i++) begin
            n_ok = n_ok + CNT_BITS'(win_ok[i]);
        end
        // Fill outside slots with low and high values so the middle slot
        // lands on the median of the inside pixels
        n_low = CNT_BITS'(MED_IDX) - (n_ok >> 1);
        n_bad = '0;
        n_s2_data.last = r_s1_last;
        for (int k = 0; k < WIN_SPAN; k++) begin
            n_s2_data.vals[k*WIN_SPAN]     = r_prev[k];
            n_s2_data.vals[k*WIN_SPAN + 1] = cur[k];
            n_s2_data.vals[k*WIN_SPAN + 2] = nxt[k];
        end
        for (int i = 0; i < WIN_SIZE; i++) begin
            if (!win_ok[i]) begin
                n_s2_data.vals[i] = (n_bad < n_low) ? '0 : '1;
                n_bad = n_bad + CNT_BITS'(1);
            end
        end
    end

    assign s2_ready = !r_s2_valid || chain_rdy[0];

    // Stage 2 registers and the column cells for the left neighbors
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_data <= n_s2_data;
            for (int k = 0; k < WIN_SPAN; k++) begin
                r_prev[k] <= cur[k];
            end
        end
    end

    // Sort chain
    assign chain_v[0]             = r_s2_valid;
    assign chain_d[0]             = r_s2_data;
    assign chain_rdy[SORT_STAGES] = i_out_ready;

    genvar gs;
    generate
        for (gs = 0; gs < SORT_STAGES; gs++) begin : g_sort
            wmf_sort_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_odd   ((gs % 2) == 1),
                .i_valid (chain_v[gs]),
                .o_ready (chain_rdy[gs]),
                .i_data  (chain_d[gs]),
                .o_valid (chain_v[gs+1]),
                .i_ready (chain_rdy[gs+1]),
                .o_data  (chain_d[gs+1])
            );
        end
    endgenerate

    assign o_out_valid             = chain_v[SORT_STAGES];
    assign o_out_data.median_value = chain_d[SORT_STAGES].vals[MED_IDX];
    assign o_out_data.frame_last   = chain_d[SORT_STAGES].last;

    // Output never runs ahead of input
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_row <= r_in_row)
        else $error("output row ahead of input row");

    // Input column stays inside the row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_col <= w_last)
        else $error("input column beyond row end");

    // Frame end restarts all counters
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last && !(cfg_acc && cfg_known)) |=>
        (r_in_row == '0 && r_in_col == '0 && r_out_row == '0 && r_out_col == '0))
        else $error("counters not cleared after frame end");

endmodule
